### design/tvda_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the terrain vertex dependency activate unit
// command codes, port widths and the controller/datapath command and status structs
package tvda_pkg;

    // fixed widths of the channel fields
    localparam int CMD_W   = 2;
    localparam int COORD_W = 9;
    localparam int COUNT_W = 17;

    // command codes carried by the cmd field (query and the spare code change nothing)
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACTIVATE = 2'd1;

    // controller to datapath
    typedef struct packed {
        logic take_in;     // latch the input word, reset count and stack
        logic rd_row;      // read the bitmap row of the target point
        logic save_prior;  // keep the target bit as the prior state
        logic wr_mark;     // set the target bit, push the target, count it
        logic clr_start;   // restart the row sweep counter
        logic clr_step;    // zero one bitmap row
        logic pop_rd;      // pop the stack top
        logic calc_nb;     // work out the two dependencies of the popped point
        logic load_n1;     // first dependency becomes the target
        logic load_n2;     // second dependency becomes the target
        logic out_load;    // load the result word
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;  // latched command
        logic hit;              // target in grid and already active
        logic tgt_ok;           // target lies in the grid
        logic full;             // stack holds its full depth
        logic empty;            // stack holds nothing
        logic clr_last;         // sweep is on the last row
        logic out_free;         // result register can take a word now
    } t_sts;

endpackage

### design/tvda_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the terrain vertex dependency activate unit
// uses tvda_pkg for the command/status structs and command codes
module tvda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tvda_pkg::t_sts i_sts,
    output tvda_pkg::t_ctl o_ctl,
    output logic          o_busy
);
    import tvda_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_POP  = 3'd4;
    localparam logic [2:0] S_POPW = 3'd5;
    localparam logic [2:0] S_NB   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    // which point the read/check pair is visiting
    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_N1   = 2'd1;
    localparam logic [1:0] PH_N2   = 2'd2;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_boot, n_boot;
    logic       w_new;

    // a fresh dependency is marked only if it fits on the stack
    assign w_new  = i_sts.tgt_ok && !i_sts.hit && !i_sts.full;
    assign o_busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_boot  = r_boot;
        o_ctl   = '0;
        unique case (r_state)
            S_CLR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.take_in = 1'b1;
                    n_phase       = PH_HEAD;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_ctl.rd_row = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                case (r_phase)
                    PH_HEAD: begin
                        o_ctl.save_prior = 1'b1;
                        if (i_sts.cmd == CMD_CLEAR) begin
                            o_ctl.clr_start = 1'b1;
                            n_state         = S_CLR;
                        end else if (i_sts.cmd == CMD_ACTIVATE && w_new) begin
                            o_ctl.wr_mark = 1'b1;
                            n_state       = S_POP;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    PH_N1: begin
                        o_ctl.wr_mark = w_new;
                        o_ctl.load_n2 = 1'b1;
                        n_phase       = PH_N2;
                        n_state       = S_RD;
                    end
                    default: begin
                        o_ctl.wr_mark = w_new;
                        n_state       = S_POP;
                    end
                endcase
            end
            S_POP: begin
                if (i_sts.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.pop_rd = 1'b1;
                    n_state      = S_POPW;
                end
            end
            S_POPW: begin
                o_ctl.calc_nb = 1'b1;
                n_state       = S_NB;
            end
            S_NB: begin
                o_ctl.load_n1 = 1'b1;
                n_phase       = PH_N1;
                n_state       = S_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers, the sweep after reset runs first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_phase <= PH_HEAD;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_boot  <= n_boot;
        end
    end

endmodule

### design/tvda_datapath.sv
`timescale 1ns / 1ps
// datapath of the terrain vertex dependency activate unit: row-wide bitmap,
// pending-point stack, dependency arithmetic and result register; uses tvda_pkg
module tvda_datapath #(
    parameter int MAP_SIZE    = 256,
    parameter int STACK_DEPTH = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tvda_pkg::t_ctl                i_ctl,
    output tvda_pkg::t_sts                o_sts,
    input  logic [tvda_pkg::CMD_W-1:0]    i_cmd,
    input  logic [tvda_pkg::COORD_W-1:0]  i_grid_x,
    input  logic [tvda_pkg::COORD_W-1:0]  i_grid_y,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_was_active,
    output logic [tvda_pkg::COUNT_W-1:0]  o_newly_active,
    output logic                          o_out_of_grid
);
    import tvda_pkg::*;

    localparam int CW  = $clog2(MAP_SIZE + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] MAP_MAX   = CW'(MAP_SIZE);
    localparam logic [CW:0]   MAP_MAX_X = (CW + 1)'(MAP_SIZE);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

    // level of a coordinate: its lowest set bit, zero counts as the map size
    function automatic logic [CW-1:0] level_of(input logic [CW-1:0] n);
        logic [CW-1:0] low;
        low = n & (~n + CW'(1));
        if (n == '0) begin
            low = MAP_MAX;
        end
        return low;
    endfunction

    // storage: one row of the grid per word, and the pending stack
    logic [MAP_SIZE:0]  mem_map [0:MAP_SIZE];
    logic [2*CW-1:0]    mem_stk [0:STACK_DEPTH-1];

    logic [CMD_W-1:0]   r_cmd;
    logic               r_inside;
    logic [CW-1:0]      r_tx, r_ty;
    logic               r_tok;
    logic [MAP_SIZE:0]  r_row;
    logic               r_prior;
    logic [COUNT_W-1:0] r_count;
    logic [DW-1:0]      r_depth;
    logic [2*CW-1:0]    r_stk_rd;
    logic [CW:0]        r_n1x, r_n1y, r_n2x, r_n2y;
    logic [CW-1:0]      r_clr;
    logic               r_ov;
    logic               r_was;
    logic [COUNT_W-1:0] r_newly;
    logic               r_oog;

    logic               w_in_ok;
    logic [CW-1:0]      w_rd_addr;
    logic [CW-1:0]      w_col;
    logic               w_hit;
    logic [MAP_SIZE:0]  w_mark;
    logic [DW-1:0]      w_depth_dec;
    logic [CW-1:0]      w_sx, w_sy, w_xl, w_yl, w_l;
    logic [CW:0]        w_xp, w_xm, w_yp, w_ym, w_l2;
    logic               w_same;
    logic [CW:0]        n_n1x, n_n1y, n_n2x, n_n2y;

    // input point against the grid, and read guards on the target
    assign w_in_ok     = (32'(i_grid_x) <= MAP_SIZE) && (32'(i_grid_y) <= MAP_SIZE);
    assign w_rd_addr   = r_tok ? r_ty : '0;
    assign w_col       = r_tok ? r_tx : '0;
    assign w_hit       = r_tok && r_row[w_col];
    assign w_mark      = {{MAP_SIZE{1'b0}}, 1'b1} << r_tx;
    assign w_depth_dec = r_depth - DW'(1);

    // dependencies of the popped point
    always_comb begin
        w_sx   = r_stk_rd[2*CW-1:CW];
        w_sy   = r_stk_rd[CW-1:0];
        w_xl   = level_of(w_sx);
        w_yl   = level_of(w_sy);
        w_l    = (w_xl < w_yl) ? w_xl : w_yl;
        w_xp   = {1'b0, w_sx} + {1'b0, w_l};
        w_xm   = {1'b0, w_sx} - {1'b0, w_l};
        w_yp   = {1'b0, w_sy} + {1'b0, w_l};
        w_ym   = {1'b0, w_sy} - {1'b0, w_l};
        w_l2   = {w_l, 1'b0};
        w_same = (({1'b0, w_sx} & w_l2) == ({1'b0, w_sy} & w_l2));
        if (w_xl > w_yl) begin
            n_n1x = w_xp;           n_n1y = {1'b0, w_sy};
            n_n2x = w_xm;           n_n2y = {1'b0, w_sy};
        end else if (w_xl < w_yl) begin
            n_n1x = {1'b0, w_sx};   n_n1y = w_ym;
            n_n2x = {1'b0, w_sx};   n_n2y = w_yp;
        end else if (w_same) begin
            n_n1x = w_xp;           n_n1y = w_ym;
            n_n2x = w_xm;           n_n2y = w_yp;
        end else begin
            n_n1x = w_xm;           n_n1y = w_ym;
            n_n2x = w_xp;           n_n2y = w_yp;
        end
    end

    // bitmap: sweep writes zero rows, marking sets one bit of the fetched row
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) begin
            mem_map[r_clr] <= '0;
        end else if (i_ctl.wr_mark) begin
            mem_map[r_ty] <= r_row | w_mark;
        end
        if (i_ctl.rd_row) begin
            r_row <= mem_map[w_rd_addr];
        end
    end

    // stack storage, push on mark and registered pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_mark) begin
            mem_stk[r_depth[SIW-1:0]] <= {r_tx, r_ty};
        end
        if (i_ctl.pop_rd) begin
            r_stk_rd <= mem_stk[w_depth_dec[SIW-1:0]];
        end
    end

    // stack depth and sweep row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_clr   <= '0;
        end else begin
            if (i_ctl.take_in) begin
                r_depth <= '0;
            end else if (i_ctl.wr_mark) begin
                r_depth <= r_depth + DW'(1);
            end else if (i_ctl.pop_rd) begin
                r_depth <= w_depth_dec;
            end
            if (i_ctl.clr_start) begin
                r_clr <= '0;
            end else if (i_ctl.clr_step) begin
                r_clr <= (r_clr == MAP_MAX) ? '0 : r_clr + CW'(1);
            end
        end
    end

    // command word, target point, prior bit, mark count, dependency registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_in) begin
            r_cmd    <= i_cmd;
            r_inside <= w_in_ok;
            r_tx     <= CW'(i_grid_x);
            r_ty     <= CW'(i_grid_y);
            r_tok    <= w_in_ok;
        end else if (i_ctl.load_n1) begin
            r_tx  <= r_n1x[CW-1:0];
            r_ty  <= r_n1y[CW-1:0];
            r_tok <= (r_n1x <= MAP_MAX_X) && (r_n1y <= MAP_MAX_X);
        end else if (i_ctl.load_n2) begin
            r_tx  <= r_n2x[CW-1:0];
            r_ty  <= r_n2y[CW-1:0];
            r_tok <= (r_n2x <= MAP_MAX_X) && (r_n2y <= MAP_MAX_X);
        end
        if (i_ctl.save_prior) begin
            r_prior <= w_hit;
        end
        if (i_ctl.take_in) begin
            r_count <= '0;
        end else if (i_ctl.wr_mark) begin
            r_count <= r_count + COUNT_W'(1);
        end
        if (i_ctl.calc_nb) begin
            r_n1x <= n_n1x;
            r_n1y <= n_n1y;
            r_n2x <= n_n2x;
            r_n2y <= n_n2y;
        end
    end

    // result register, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_was   <= r_prior;
            r_newly <= r_count;
            r_oog   <= !r_inside;
        end
    end

    assign o_valid        = r_ov;
    assign o_was_active   = r_was;
    assign o_newly_active = r_newly;
    assign o_out_of_grid  = r_oog;

    // status back to the sequencer
    assign o_sts.cmd      = r_cmd;
    assign o_sts.hit      = w_hit;
    assign o_sts.tgt_ok   = r_tok;
    assign o_sts.full     = (r_depth == DEPTH_MAX);
    assign o_sts.empty    = (r_depth == '0);
    assign o_sts.clr_last = (r_clr == MAP_MAX);
    assign o_sts.out_free = !r_ov || !i_stall;

endmodule

### design/terrain_vertex_dependency_activate_unit.sv
`timescale 1ns / 1ps
// Terrain vertex dependency activate unit.
// Input channel: i_valid / o_stall carry one command word (i_cmd, i_grid_x,
// i_grid_y); clear all, activate point with all its dependencies, or query.
// Output channel: o_valid / i_stall carry one result word per command
// (o_was_active, o_newly_active, o_out_of_grid).
// Commands run one at a time; o_stall stays high while a command is in work.
// From accept to o_valid: a query, an off-grid or an already-active point takes
// one read and check of its bitmap row; activate adds, per vertex taken off the
// pending stack, a pop, the dependency arithmetic and a read and check of the
// bitmap row for each of the two dependencies; clear sweeps MAP_SIZE+1 rows,
// one bitmap row zeroed a cycle. The next word is taken at the earliest in the
// cycle in which o_valid rises. The single-port bitmap row read-modify-write
// sets the pace of activation. After reset the bitmap is swept clear, all
// MAP_SIZE+1 rows, with o_stall high. A result that the receiver stalls stays
// in the output register; the next command is accepted meanwhile and waits at
// its end for that register.
// MAP_SIZE must be a power of two; the block itself does not enforce it.
// Uses tvda_pkg, tvda_ctrl and tvda_datapath.
module terrain_vertex_dependency_activate_unit #(
    parameter int MAP_SIZE    = 256,
    parameter int STACK_DEPTH = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tvda_pkg::CMD_W-1:0]    i_cmd,
    input  logic [tvda_pkg::COORD_W-1:0]  i_grid_x,
    input  logic [tvda_pkg::COORD_W-1:0]  i_grid_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_was_active,
    output logic [tvda_pkg::COUNT_W-1:0]  o_newly_active,
    output logic                          o_out_of_grid
);
    import tvda_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    // sequencer
    tvda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (o_stall)
    );

    // bitmap, stack and result datapath
    tvda_datapath #(
        .MAP_SIZE    (MAP_SIZE),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_cmd          (i_cmd),
        .i_grid_x       (i_grid_x),
        .i_grid_y       (i_grid_y),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_was_active   (o_was_active),
        .o_newly_active (o_newly_active),
        .o_out_of_grid  (o_out_of_grid)
    );

endmodule

### design/tvda_checker.sv
`timescale 1ns / 1ps
// port-level checks of the terrain vertex dependency activate unit
// bound to the top level below; uses tvda_pkg for field widths
module tvda_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_was_active,
    input logic [tvda_pkg::COUNT_W-1:0]  o_newly_active,
    input logic                          o_out_of_grid
);
    import tvda_pkg::*;

    // no result word straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word shown after reset");

    // a point outside the grid reports nothing (a clear still sweeps the bitmap)
    a_oog_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_grid |-> !o_was_active && o_newly_active == '0)
        else $error("out-of-grid word carries activity");

    // an already active point marks nothing new
    a_prior_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_active |-> o_newly_active == '0)
        else $error("new marks reported for an active point");

    // one command at a time: an accepted word stalls the next
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word accepted while a command is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_newly_active))
        else $error("stalled result word changed");

endmodule

bind terrain_vertex_dependency_activate_unit tvda_checker u_tvda_checker (.*);
